[sv/csvtok_pkg.sv]
package csvtok_pkg;

  localparam int MaxFields = 64;
  localparam int LineBits  = 32;

  localparam int CountBits = $clog2(MaxFields + 1);

  localparam int CfgBits   = 7;
  localparam int FieldBits = 6;
  localparam int RecLineBits = 32;

  localparam logic [CfgBits-1:0]   CfgReset = CfgBits'(5);

  localparam logic [7:0] CharQuote = 8'h22;
  localparam logic [7:0] CharComma = 8'h2c;
  localparam logic [7:0] CharLf    = 8'h0a;

  typedef enum logic [1:0] {
    ST_START    = 2'd0,
    ST_UNQUOTED = 2'd1,
    ST_QUOTED   = 2'd2,
    ST_AFTER    = 2'd3
  } parse_state_t;

  typedef enum logic [1:0] {
    KIND_CONTENT = 2'd0,
    KIND_FIELD   = 2'd1,
    KIND_RECORD  = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_JUNK_AFTER_QUOTE = 2'd0,
    ERR_QUOTE_IN_FIELD   = 2'd1,
    ERR_UNCLOSED_QUOTE   = 2'd2,
    ERR_FIELD_COUNT      = 2'd3
  } err_t;

endpackage

[sv/csv_record_tokenizer.sv]
// Channel   | Handshake                | Payload
// ----------+--------------------------+-------------------------------------------
// input     | in_valid / in_ready      | mode, data_byte
// output    | out_valid / out_ready    | kind, content_byte, field_number,
//           |                          | record_line, error_code
// config    | cfg_valid / cfg_ready    | cfg_data (expected_fields)
//
// Each input transfer is decided in the cycle it is accepted; its result, if any,
// appears in the output register on the next cycle. One byte per cycle is sustained while out_ready stays high.
// The only limit on rate is the single output register: in_ready is high whenever that
// register is empty or is being drained by an output transfer in the same cycle.
// Reset (rst, synchronous, active high) returns the parser to the start of a text and
// sets expected_fields to 5. The config port is always ready.
module csv_record_tokenizer
  import csvtok_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,

  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   mode,
  input  logic [7:0]             data_byte,

  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             kind,
  output logic [7:0]             content_byte,
  output logic [FieldBits-1:0]   field_number,
  output logic [RecLineBits-1:0] record_line,
  output logic [1:0]             error_code,

  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CfgBits-1:0]     cfg_data
);

  // Parser state. The field counter needs one extra bit because it saturates at
  // MaxFields itself, one beyond the largest reported field number.
  parse_state_t          state, state_next;
  logic                  stopped, stopped_next;
  logic                  record_open, record_open_next;
  logic [CountBits-1:0]  field_count, field_count_next;
  logic [LineBits-1:0]   current_line, current_line_next;
  logic [LineBits-1:0]   start_line, start_line_next;
  logic [CfgBits-1:0]    expected_fields;

  logic                  accept;
  logic                  is_quote, is_comma, is_lf;
  logic                  count_bad;
  logic [LineBits-1:0]   line_bumped;

  // Result decided for the transfer being accepted.
  logic                  res_valid;
  kind_t                 res_kind;
  logic [7:0]            res_byte;
  err_t                  res_code;

  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign is_quote = (data_byte == CharQuote);
  assign is_comma = (data_byte == CharComma);
  assign is_lf    = (data_byte == CharLf);

  // The record has field_count + 1 fields. A nonzero setting above MaxFields can
  // never be met because the counter saturates there.
  always_comb begin
    count_bad = 1'b0;
    if (expected_fields != '0) begin
      if ({1'b0, expected_fields} > (CfgBits + 1)'(MaxFields)) begin
        count_bad = 1'b1;
      end else begin
        count_bad = ({1'b0, expected_fields} !=
                     ((CfgBits + 1)'(field_count) + (CfgBits + 1)'(1)));
      end
    end
  end

  // Line counter saturates at its all-ones value.
  assign line_bumped = (current_line == '1) ? current_line : current_line + LineBits'(1);

  // Next state.
  always_comb begin
    state_next        = state;
    stopped_next      = stopped;
    record_open_next  = record_open;
    field_count_next  = field_count;
    current_line_next = current_line;
    start_line_next   = start_line;
    if (accept) begin
      if (mode) begin
        // End of text: everything returns to the start of a new text.
        state_next        = ST_START;
        stopped_next      = 1'b0;
        record_open_next  = 1'b0;
        field_count_next  = '0;
        current_line_next = LineBits'(1);
        start_line_next   = LineBits'(1);
      end else if (!stopped) begin
        record_open_next = 1'b1;
        if (state == ST_QUOTED) begin
          if (is_quote) begin
            state_next = ST_AFTER;
          end else if (is_lf) begin
            current_line_next = line_bumped;
          end
        end else if (is_comma) begin
          if (field_count != CountBits'(MaxFields)) begin
            field_count_next = field_count + CountBits'(1);
          end
          state_next = ST_START;
        end else if (is_lf) begin
          if (count_bad) begin
            stopped_next = 1'b1;
          end else begin
            current_line_next = line_bumped;
            start_line_next   = line_bumped;
            field_count_next  = '0;
            record_open_next  = 1'b0;
            state_next        = ST_START;
          end
        end else if (state == ST_AFTER) begin
          if (is_quote) begin
            state_next = ST_QUOTED;
          end else begin
            stopped_next = 1'b1;
          end
        end else if (is_quote) begin
          if (state != ST_START) begin
            stopped_next = 1'b1;
          end else begin
            state_next = ST_QUOTED;
          end
        end else begin
          state_next = ST_UNQUOTED;
        end
      end
    end
  end

  // Result of the accepted transfer, decided from the state before it.
  always_comb begin
    res_valid = 1'b0;
    res_kind  = KIND_CONTENT;
    res_byte  = 8'h00;
    res_code  = ERR_JUNK_AFTER_QUOTE;
    if (mode) begin
      if (!stopped && record_open) begin
        res_valid = 1'b1;
        if (state == ST_QUOTED) begin
          res_kind = KIND_ERROR;
          res_code = ERR_UNCLOSED_QUOTE;
        end else if (count_bad) begin
          res_kind = KIND_ERROR;
          res_code = ERR_FIELD_COUNT;
        end else begin
          res_kind = KIND_RECORD;
        end
      end
    end else if (!stopped) begin
      res_valid = 1'b1;
      if (state == ST_QUOTED) begin
        if (is_quote) begin
          res_valid = 1'b0;
        end else begin
          res_byte = data_byte;
        end
      end else if (is_comma) begin
        res_kind = KIND_FIELD;
      end else if (is_lf) begin
        if (count_bad) begin
          res_kind = KIND_ERROR;
          res_code = ERR_FIELD_COUNT;
        end else begin
          res_kind = KIND_RECORD;
        end
      end else if (state == ST_AFTER) begin
        if (is_quote) begin
          res_byte = data_byte;
        end else begin
          res_kind = KIND_ERROR;
          res_code = ERR_JUNK_AFTER_QUOTE;
        end
      end else if (is_quote) begin
        if (state != ST_START) begin
          res_kind = KIND_ERROR;
          res_code = ERR_QUOTE_IN_FIELD;
        end else begin
          res_valid = 1'b0;
        end
      end else begin
        res_byte = data_byte;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_START;
      stopped         <= 1'b0;
      record_open     <= 1'b0;
      field_count     <= '0;
      current_line    <= LineBits'(1);
      start_line      <= LineBits'(1);
      expected_fields <= CfgReset;
      out_valid       <= 1'b0;
    end else begin
      state        <= state_next;
      stopped      <= stopped_next;
      record_open  <= record_open_next;
      field_count  <= field_count_next;
      current_line <= current_line_next;
      start_line   <= start_line_next;
      if (cfg_valid && cfg_ready) begin
        expected_fields <= cfg_data;
      end
      if (accept) begin
        out_valid <= res_valid;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload register. Field number and line describe the state at the time
  // the result was decided, before this transfer's own update.
  always_ff @(posedge clk) begin
    if (accept) begin
      kind         <= res_kind;
      content_byte <= res_byte;
      error_code   <= (res_kind == KIND_ERROR) ? res_code : ERR_JUNK_AFTER_QUOTE;
      field_number <= (field_count > CountBits'((1 << FieldBits) - 1)) ?
                      '1 : FieldBits'(field_count);
      if (LineBits > RecLineBits) begin
        record_line <= (start_line > LineBits'({RecLineBits{1'b1}})) ?
                       '1 : RecLineBits'(start_line);
      end else begin
        record_line <= RecLineBits'(start_line);
      end
    end
  end

endmodule

[test/csv_record_tokenizer_test.sv]
`timescale 1ns / 100ps

module csv_record_tokenizer_test;
  import csvtok_pkg::*;

  // One decoded token as the block reports it. The kind decides which of the other
  // fields carry meaning; the rest are expected to read as zero.
  typedef struct packed {
    kind_t                  kind;
    logic [7:0]             content;
    logic [FieldBits-1:0]   field;
    logic [RecLineBits-1:0] line;
    logic [1:0]             code;
  } token_t;

  // A row of the directed stimulus. When hand_typed is set, the token (or the absence
  // of one, given by hand_any) is taken from the row; otherwise the tokenizer model
  // below decides what the row must produce.
  typedef struct {
    logic       mode;
    logic [7:0] data;
    bit         hand_typed;
    bit         hand_any;
    token_t     tok;
  } dir_row_t;

  localparam longint unsigned LineMax = (64'd1 << LineBits) - 1;
  localparam int FieldNumMax = (1 << FieldBits) - 1;
  localparam int RandomItems = 1250;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               mode = 1'b0;
  logic [7:0]         data_byte = 8'h00;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         kind;
  logic [7:0]         content_byte;
  logic [FieldBits-1:0]   field_number;
  logic [RecLineBits-1:0] record_line;
  logic [1:0]         error_code;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgBits-1:0] cfg_data = '0;

  csv_record_tokenizer u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .content_byte (content_byte),
    .field_number (field_number),
    .record_line  (record_line),
    .error_code   (error_code),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // The run is bounded no matter what the block does with its handshakes.
  initial begin
    #20000000;
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tokenizer model: a private copy of the parser state and of expected_fields.
  // It is advanced once for every input transfer, at the edge of that transfer.
  // ---------------------------------------------------------------------------
  parse_state_t       tk_state;
  bit                 tk_stopped;
  bit                 tk_open;
  int unsigned        tk_fields;
  longint unsigned    tk_cur_line;
  longint unsigned    tk_start_line;
  logic [CfgBits-1:0] tk_expected;

  token_t pending_tokens[$];
  int     fail_count = 0;
  int     items_done = 0;

  // Knobs set by the stimulus: send_gappy for the sender, hold_req for the receiver.
  bit send_gappy = 1'b0;
  logic hold_req = 1'b0;

  function automatic void clear_parser();
    tk_state      = ST_START;
    tk_stopped    = 1'b0;
    tk_open       = 1'b0;
    tk_fields     = 0;
    tk_cur_line   = 1;
    tk_start_line = 1;
  endfunction

  // Builds a token from the current record context. Content is only carried by
  // content tokens; the error code is filled in by the caller for errors.
  function automatic token_t record_token(kind_t k, logic [7:0] b);
    token_t t;
    t.kind    = k;
    t.content = (k == KIND_CONTENT) ? b : 8'h00;
    t.field   = (tk_fields > FieldNumMax) ? FieldBits'(FieldNumMax) : FieldBits'(tk_fields);
    t.line    = (tk_start_line > 64'hFFFF_FFFF) ? '1 : tk_start_line[RecLineBits-1:0];
    t.code    = 2'd0;
    return t;
  endfunction

  function automatic token_t error_token(err_t code);
    token_t t;
    t = record_token(KIND_ERROR, 8'h00);
    t.code = code;
    return t;
  endfunction

  // The record has tk_fields + 1 fields; a zero setting turns the check off and a
  // setting beyond the field capacity can never be met.
  function automatic bit field_count_wrong();
    if (tk_expected == 0) return 1'b0;
    if (tk_expected > MaxFields) return 1'b1;
    return (tk_fields + 1) != tk_expected;
  endfunction

  function automatic void count_line();
    if (tk_cur_line < LineMax) tk_cur_line++;
  endfunction

  // Advances the model by one input item. Returns 1 when the item yields a token.
  function automatic bit tokenize_step(logic m, logic [7:0] b, output token_t t);
    bit got;
    got = 1'b0;
    t = '0;
    if (m) begin
      // End of text closes an open record (or reports it unclosed) and rewinds the
      // parser; the field count setting survives.
      if (!tk_stopped && tk_open) begin
        got = 1'b1;
        if (tk_state == ST_QUOTED) t = error_token(ERR_UNCLOSED_QUOTE);
        else if (field_count_wrong()) t = error_token(ERR_FIELD_COUNT);
        else t = record_token(KIND_RECORD, 8'h00);
      end
      clear_parser();
      return got;
    end
    if (tk_stopped) return 1'b0;
    tk_open = 1'b1;

    if (tk_state == ST_QUOTED) begin
      if (b == CharQuote) begin
        tk_state = ST_AFTER;
        return 1'b0;
      end
      if (b == CharLf) count_line();
      t = record_token(KIND_CONTENT, b);
      return 1'b1;
    end
    if (b == CharComma) begin
      t = record_token(KIND_FIELD, 8'h00);
      if (tk_fields < MaxFields) tk_fields++;
      tk_state = ST_START;
      return 1'b1;
    end
    if (b == CharLf) begin
      if (field_count_wrong()) begin
        t = error_token(ERR_FIELD_COUNT);
        tk_stopped = 1'b1;
        return 1'b1;
      end
      t = record_token(KIND_RECORD, 8'h00);
      count_line();
      tk_start_line = tk_cur_line;
      tk_fields = 0;
      tk_open = 1'b0;
      tk_state = ST_START;
      return 1'b1;
    end
    if (tk_state == ST_AFTER) begin
      // A second quote is a literal quote; anything else after a closing quote is junk.
      if (b == CharQuote) begin
        tk_state = ST_QUOTED;
        t = record_token(KIND_CONTENT, b);
        return 1'b1;
      end
      t = error_token(ERR_JUNK_AFTER_QUOTE);
      tk_stopped = 1'b1;
      return 1'b1;
    end
    if (b == CharQuote) begin
      if (tk_state != ST_START) begin
        t = error_token(ERR_QUOTE_IN_FIELD);
        tk_stopped = 1'b1;
        return 1'b1;
      end
      tk_state = ST_QUOTED;
      return 1'b0;
    end
    tk_state = ST_UNQUOTED;
    t = record_token(KIND_CONTENT, b);
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: accepts tokens, compares them with the oldest pending token, and
  // throttles out_ready. A long hold-off, requested once by the stimulus, lets
  // the single output register fill so that in_ready drops.
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  bit hold_done = 1'b0;
  bit recv_gappy = 1'b0;
  int recv_tick = 0;

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_token();
    token_t want;
    if (pending_tokens.size() == 0) begin
      $display("%0t: token with none pending, expected nothing, got kind %0d", $time, kind);
      fail_count++;
    end else begin
      want = pending_tokens.pop_front();
      check_field("kind", want.kind, kind);
      check_field("content_byte", want.content, content_byte);
      check_field("field_number", want.field, field_number);
      check_field("record_line", want.line, record_line);
      check_field("error_code", want.code, error_code);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) check_token();

    // Switch between throttled and free-running stretches every so often.
    recv_tick++;
    if (recv_tick % 256 == 0) recv_gappy = ($urandom_range(0, 2) != 0);

    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      stall_left = 300;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (recv_gappy && $urandom_range(0, 99) >= 65) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side.
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    if (!send_gappy) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offers one item and waits for its transfer; the model is stepped at the edge of
  // the transfer. Valid is only lowered when a gap follows, so back-to-back items
  // never see two assignments to in_valid in one step.
  task automatic put_byte(logic m, logic [7:0] b, bit hand_typed = 1'b0,
                          bit hand_any = 1'b0, token_t hand_tok = '0);
    int gap;
    bit got;
    token_t t;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    mode      <= m;
    data_byte <= b;
    do @(posedge clk); while (!in_ready);
    items_done++;
    got = tokenize_step(m, b, t);
    if (hand_typed) begin
      got = hand_any;
      t = hand_tok;
    end
    if (got) pending_tokens = {pending_tokens, t};
  endtask

  // Stops offering input and waits until every pending token has arrived, then lets
  // an item that produces no token settle.
  task automatic drain_tokens();
    in_valid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_expected_fields(logic [CfgBits-1:0] v);
    drain_tokens();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    tk_expected = v;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == CharQuote || b == CharComma || b == CharLf);
    return b;
  endfunction

  // Stray bytes biased toward the delimiters, to break otherwise clean records.
  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 3))
      0: return CharQuote;
      1: return CharComma;
      2: return CharLf;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly the configured count, so records get through the check, with the odd
  // short record and the odd one long enough to saturate the field counter.
  function automatic int pick_field_count();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom_range(MaxFields + 1, MaxFields + 6);
    if (r < 14 && tk_expected >= 1 && tk_expected <= MaxFields) return int'(tk_expected);
    return $urandom_range(1, 6);
  endfunction

  task automatic send_field();
    int len;
    if ($urandom_range(0, 24) == 0) put_byte(1'b0, noise_byte());
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 4);
    if ($urandom_range(0, 9) < 6) begin
      for (int i = 0; i < len; i++) put_byte(1'b0, plain_byte());
    end else begin
      // Quoted content exercises doubled quotes, embedded commas and embedded newlines.
      put_byte(1'b0, CharQuote);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(0, 7))
          0: begin
            put_byte(1'b0, CharQuote);
            put_byte(1'b0, CharQuote);
          end
          1: put_byte(1'b0, CharComma);
          2: put_byte(1'b0, CharLf);
          default: put_byte(1'b0, plain_byte());
        endcase
      end
      put_byte(1'b0, CharQuote);
    end
  endtask

  task automatic send_record(int nf, bit close);
    for (int f = 0; f < nf; f++) begin
      send_field();
      if (f < nf - 1) put_byte(1'b0, CharComma);
    end
    if (close) put_byte(1'b0, CharLf);
  endtask

  // One text: a few records, sometimes a blank line, sometimes a last record left
  // open or an unclosed quote, always closed by end of text with a random data byte.
  task automatic send_text();
    int nrec;
    nrec = $urandom_range(1, 4);
    for (int r = 0; r < nrec; r++) begin
      if ($urandom_range(0, 19) == 0) put_byte(1'b0, CharLf);
      send_record(pick_field_count(), !(r == nrec - 1 && $urandom_range(0, 3) == 0));
    end
    if ($urandom_range(0, 19) == 0) begin
      put_byte(1'b0, CharQuote);
      put_byte(1'b0, plain_byte());
    end
    put_byte(1'b1, 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 9) == 0) put_byte(1'b1, 8'($urandom_range(0, 255)));
  endtask

  function automatic token_t tok(kind_t k, logic [7:0] b, int fld, int ln, err_t code);
    token_t t;
    t.kind    = k;
    t.content = b;
    t.field   = FieldBits'(fld);
    t.line    = RecLineBits'(ln);
    t.code    = (k == KIND_ERROR) ? code : 2'd0;
    return t;
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  dir_row_t dir_rows[$];
  logic [CfgBits-1:0] cfg_plan[8];

  initial begin
    clear_parser();
    tk_expected = CfgReset;

    // Directed text under the reset setting of five fields. Rows marked hand-typed
    // carry their token; the rest are left to the model.
    dir_rows = '{
      // First content byte and first field end right after reset.
      '{1'b0, 8'h61,     1'b1, 1'b1, tok(KIND_CONTENT, 8'h61, 0, 1, ERR_JUNK_AFTER_QUOTE)},
      '{1'b0, CharComma, 1'b1, 1'b1, tok(KIND_FIELD, 8'h00, 0, 1, ERR_JUNK_AFTER_QUOTE)},
      // A quoted field holding a comma, a newline and a doubled quote.
      '{1'b0, CharQuote, 1'b1, 1'b0, '0},
      '{1'b0, CharComma, 1'b0, 1'b0, '0},
      '{1'b0, CharLf,    1'b0, 1'b0, '0},
      '{1'b0, CharQuote, 1'b0, 1'b0, '0},
      '{1'b0, CharQuote, 1'b0, 1'b0, '0},
      '{1'b0, CharQuote, 1'b0, 1'b0, '0},
      '{1'b0, CharComma, 1'b0, 1'b0, '0},
      // Extreme byte values are plain content.
      '{1'b0, 8'hFF,     1'b1, 1'b1, tok(KIND_CONTENT, 8'hFF, 2, 1, ERR_JUNK_AFTER_QUOTE)},
      '{1'b0, 8'h00,     1'b1, 1'b1, tok(KIND_CONTENT, 8'h00, 2, 1, ERR_JUNK_AFTER_QUOTE)},
      // An empty field, then the record end with exactly five fields.
      '{1'b0, CharComma, 1'b0, 1'b0, '0},
      '{1'b0, CharComma, 1'b0, 1'b0, '0},
      '{1'b0, CharLf,    1'b0, 1'b0, '0},
      // A blank line is a record of one field and fails the count on line three.
      '{1'b0, CharLf,    1'b1, 1'b1, tok(KIND_ERROR, 8'h00, 0, 3, ERR_FIELD_COUNT)},
      // Bytes after an error are dropped, and so is the end of text.
      '{1'b0, 8'h78,     1'b1, 1'b0, '0},
      '{1'b1, 8'hFF,     1'b1, 1'b0, '0},
      // A quote inside an unquoted field.
      '{1'b0, 8'h61,     1'b1, 1'b1, tok(KIND_CONTENT, 8'h61, 0, 1, ERR_JUNK_AFTER_QUOTE)},
      '{1'b0, CharQuote, 1'b1, 1'b1, tok(KIND_ERROR, 8'h00, 0, 1, ERR_QUOTE_IN_FIELD)},
      '{1'b1, 8'h00,     1'b1, 1'b0, '0},
      // Junk after a closing quote.
      '{1'b0, CharQuote, 1'b0, 1'b0, '0},
      '{1'b0, CharQuote, 1'b0, 1'b0, '0},
      '{1'b0, 8'h62,     1'b1, 1'b1, tok(KIND_ERROR, 8'h00, 0, 1, ERR_JUNK_AFTER_QUOTE)},
      '{1'b1, 8'h5A,     1'b1, 1'b0, '0},
      // A quote left open at end of text, then an end of text with nothing open.
      '{1'b0, CharQuote, 1'b0, 1'b0, '0},
      '{1'b0, CharLf,    1'b0, 1'b0, '0},
      '{1'b1, 8'hA5,     1'b1, 1'b1, tok(KIND_ERROR, 8'h00, 0, 1, ERR_UNCLOSED_QUOTE)},
      '{1'b1, 8'h00,     1'b1, 1'b0, '0}
    };

    // Settings for the random phases: check off, the largest count the block can meet,
    // unreachable counts, the smallest count, small counts, a random small one and the reset one.
    cfg_plan = '{7'd0, 7'd64, 7'd127, 7'd1, 7'd65, 7'd3, 7'($urandom_range(1, 8)), 7'd5};

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      put_byte(dir_rows[i].mode, dir_rows[i].data, dir_rows[i].hand_typed,
               dir_rows[i].hand_any, dir_rows[i].tok);

    items_done = 0;
    for (int p = 0; p <= 8; p++) begin
      if (p > 0) write_expected_fields(cfg_plan[p-1]);
      send_gappy = ($urandom_range(0, 2) != 0);
      if (p == 2) begin
        // Keep offering bytes back to back while the receiver holds off.
        send_gappy = 1'b0;
        hold_req <= 1'b1;
      end
      send_text();
      // Once, the sender waits for the output to run dry in the middle of a phase.
      if (p == 4) drain_tokens();
      while (items_done < (p + 1) * RandomItems / 9) send_text();
    end

    drain_tokens();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
